// File: design/csb_pkg.sv
// Package: sizes, operation codes, status codes and shift control type for the cursor buffer.
`timescale 1ns / 1ps
package csb_pkg;

    localparam int CAPACITY_ENTRIES = 32;
    localparam int WORD_BITS        = 32;
    localparam int IDX_BITS         = $clog2(CAPACITY_ENTRIES);
    localparam int CNT_BITS         = $clog2(CAPACITY_ENTRIES + 1);
    localparam int MODE_BITS        = 4;
    localparam int STATUS_BITS      = 2;
    localparam int READ_IDX_BITS    = 5;
    localparam int OUT_CNT_BITS     = 6;

    localparam logic [MODE_BITS-1:0] MODE_START        = 4'd0;
    localparam logic [MODE_BITS-1:0] MODE_END          = 4'd1;
    localparam logic [MODE_BITS-1:0] MODE_ADVANCE      = 4'd2;
    localparam logic [MODE_BITS-1:0] MODE_RETREAT      = 4'd3;
    localparam logic [MODE_BITS-1:0] MODE_INSERT       = 4'd4;
    localparam logic [MODE_BITS-1:0] MODE_ATTACH       = 4'd5;
    localparam logic [MODE_BITS-1:0] MODE_REMOVE       = 4'd6;
    localparam logic [MODE_BITS-1:0] MODE_INSERT_FRONT = 4'd7;
    localparam logic [MODE_BITS-1:0] MODE_ATTACH_BACK  = 4'd8;
    localparam logic [MODE_BITS-1:0] MODE_REMOVE_FRONT = 4'd9;
    localparam logic [MODE_BITS-1:0] MODE_READ_INDEX   = 4'd10;

    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_NO_ITEM   = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_BAD_INDEX = 2'd3;

    localparam logic [1:0] SHIFT_HOLD  = 2'd0;
    localparam logic [1:0] SHIFT_OPEN  = 2'd1;
    localparam logic [1:0] SHIFT_CLOSE = 2'd2;

    typedef struct packed {
        logic [1:0]           op;
        logic [IDX_BITS-1:0]  pos;
        logic [WORD_BITS-1:0] word;
    } t_shift_ctrl;

endpackage

// File: design/csb_if.sv
// Interfaces: request and response channels of the cursor buffer.
`timescale 1ns / 1ps
interface csb_req_if
    import csb_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [MODE_BITS-1:0]     mode;
    logic [WORD_BITS-1:0]     entry_value;
    logic [READ_IDX_BITS-1:0] read_index;

    modport source (output valid, mode, entry_value, read_index, input ready);
    modport sink   (input valid, mode, entry_value, read_index, output ready);
endinterface

interface csb_rsp_if
    import csb_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [WORD_BITS-1:0]    item_value;
    logic                    has_item;
    logic [OUT_CNT_BITS-1:0] item_count;
    logic [OUT_CNT_BITS-1:0] cursor_pos;
    logic [STATUS_BITS-1:0]  status;

    modport source (output valid, item_value, has_item, item_count, cursor_pos, status,
                    input ready);
    modport sink   (input valid, item_value, has_item, item_count, cursor_pos, status,
                    output ready);
endinterface

// File: design/cursor_sequence_buffer.sv
// Top level: cursor buffer built from a row of shifting cells with a registered response.
// Response path: an accepted request moves through the pending stage and then the response
//   register before its response is valid on the channel.
// Throughput: one request per cycle unless the response stalls; the cell row shifts all
//   entries on accept; one registered read mux picks the word when pending advances.
// Reset (synchronous, active low) clears the entry count, the cursor and both stage
//   valids; cell contents stay undefined until written, no clearing pass is needed.
`timescale 1ns / 1ps
module cursor_sequence_buffer
    import csb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    csb_req_if.sink   i_req,
    csb_rsp_if.source o_rsp
);

    t_shift_ctrl            w_shift;
    logic [STATUS_BITS-1:0] w_status;
    logic [CNT_BITS-1:0]    w_count;
    logic [CNT_BITS-1:0]    w_cursor;
    logic                   w_fire;
    logic                   w_pend_advance;
    logic [WORD_BITS-1:0]   w_cell_value [CAPACITY_ENTRIES];
    logic [IDX_BITS-1:0]    w_rd_addr;
    logic                   w_rd_ok;
    logic [WORD_BITS-1:0]   w_rd_value;

    // Pending stage: the request has updated the cells, its word is read next.
    logic                     r_pend_valid;
    logic                     r_pend_read;
    logic [READ_IDX_BITS-1:0] r_pend_idx;
    logic [STATUS_BITS-1:0]   r_pend_status;

    // Response register.
    logic                    r_out_valid;
    logic [WORD_BITS-1:0]    r_out_value;
    logic                    r_out_has;
    logic [OUT_CNT_BITS-1:0] r_out_count;
    logic [OUT_CNT_BITS-1:0] r_out_cursor;
    logic [STATUS_BITS-1:0]  r_out_status;

    assign w_fire         = i_req.valid && i_req.ready;
    assign w_pend_advance = r_pend_valid && (!r_out_valid || o_rsp.ready);
    // Accept only when the pending stage empties this cycle, so the cells are read
    // before the next request shifts them.
    assign i_req.ready    = !r_pend_valid || w_pend_advance;

    csb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_mode     (i_req.mode),
        .i_word     (i_req.entry_value),
        .i_read_idx (i_req.read_index),
        .o_shift    (w_shift),
        .o_status   (w_status),
        .o_count    (w_count),
        .o_cursor   (w_cursor)
    );

    // Row of cells; the ends see zero from the missing neighbor.
    for (genvar k = 0; k < CAPACITY_ENTRIES; k++) begin : g_cell
        logic [WORD_BITS-1:0] w_left;
        logic [WORD_BITS-1:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_value[k-1];
        end
        if (k == CAPACITY_ENTRIES - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell_value[k+1];
        end
        csb_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (w_shift),
            .i_cell_idx (IDX_BITS'(k)),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_value    (w_cell_value[k])
        );
    end

    // Read the word at the index or at the cursor; report zero with no valid entry.
    always_comb begin
        if (r_pend_read) begin
            w_rd_addr = r_pend_idx[IDX_BITS-1:0];
            w_rd_ok   = r_pend_status != STATUS_BAD_INDEX;
        end else begin
            w_rd_addr = w_cursor[IDX_BITS-1:0];
            w_rd_ok   = w_cursor < w_count;
        end
        w_rd_value = w_rd_ok ? w_cell_value[w_rd_addr] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (w_fire) begin
            r_pend_valid <= 1'b1;
        end else if (w_pend_advance) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_pend_read   <= i_req.mode == MODE_READ_INDEX;
            r_pend_idx    <= i_req.read_index;
            r_pend_status <= w_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pend_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pend_advance) begin
            r_out_value  <= w_rd_value;
            r_out_has    <= w_cursor < w_count;
            r_out_count  <= OUT_CNT_BITS'(w_count);
            r_out_cursor <= OUT_CNT_BITS'(w_cursor);
            r_out_status <= r_pend_status;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.item_value = r_out_value;
    assign o_rsp.has_item   = r_out_has;
    assign o_rsp.item_count = r_out_count;
    assign o_rsp.cursor_pos = r_out_cursor;
    assign o_rsp.status     = r_out_status;

    a_out_from_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_pend_valid))
        else $error("response appeared without a pending request");

    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && r_out_valid && !o_rsp.ready) |-> !w_fire)
        else $error("request accepted while pending read was blocked");

    a_pend_follows_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_pend_valid)
        else $error("accepted request lost before read");

endmodule

// File: design/csb_cell.sv
// Cell: one stored word of the list, shifting toward or away from its neighbors.
`timescale 1ns / 1ps
module csb_cell
    import csb_pkg::*;
(
    input  logic                 i_clk,
    input  t_shift_ctrl          i_shift,
    input  logic [IDX_BITS-1:0]  i_cell_idx,
    input  logic [WORD_BITS-1:0] i_left,
    input  logic [WORD_BITS-1:0] i_right,
    output logic [WORD_BITS-1:0] o_value
);

    logic [WORD_BITS-1:0] r_value;
    logic [WORD_BITS-1:0] n_value;

    always_comb begin
        n_value = r_value;
        unique case (i_shift.op)
            SHIFT_OPEN: begin
                if (i_cell_idx > i_shift.pos) begin
                    n_value = i_left;
                end else if (i_cell_idx == i_shift.pos) begin
                    n_value = i_shift.word;
                end
            end
            SHIFT_CLOSE: begin
                if (i_cell_idx >= i_shift.pos) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// File: design/csb_ctrl.sv
// Control: entry count, cursor, per-request status and the shift command for the cell row.
`timescale 1ns / 1ps
module csb_ctrl
    import csb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic [MODE_BITS-1:0]     i_mode,
    input  logic [WORD_BITS-1:0]     i_word,
    input  logic [READ_IDX_BITS-1:0] i_read_idx,
    output t_shift_ctrl              o_shift,
    output logic [STATUS_BITS-1:0]   o_status,
    output logic [CNT_BITS-1:0]      o_count,
    output logic [CNT_BITS-1:0]      o_cursor
);

    logic [CNT_BITS-1:0]    r_count;
    logic [CNT_BITS-1:0]    r_cursor;
    logic [CNT_BITS-1:0]    n_count;
    logic [CNT_BITS-1:0]    n_cursor;
    logic [CNT_BITS-1:0]    w_pos;
    logic [1:0]             w_op;
    logic [STATUS_BITS-1:0] w_status;
    logic                   w_has;
    logic                   w_full;

    assign w_has  = r_cursor < r_count;
    assign w_full = r_count >= CNT_BITS'(CAPACITY_ENTRIES);

    always_comb begin
        n_count  = r_count;
        n_cursor = r_cursor;
        w_pos    = '0;
        w_op     = SHIFT_HOLD;
        w_status = STATUS_OK;
        unique case (i_mode)
            MODE_START: n_cursor = '0;
            MODE_END: n_cursor = (r_count != '0) ? r_count - 1'b1 : '0;
            MODE_ADVANCE: begin
                if (!w_has) w_status = STATUS_NO_ITEM;
                else n_cursor = r_cursor + 1'b1;
            end
            MODE_RETREAT: begin
                if (r_cursor != '0) n_cursor = r_cursor - 1'b1;
            end
            MODE_INSERT, MODE_ATTACH, MODE_INSERT_FRONT, MODE_ATTACH_BACK: begin
                if (w_full) begin
                    w_status = STATUS_FULL;
                end else begin
                    priority if (i_mode == MODE_INSERT) begin
                        w_pos = w_has ? r_cursor : '0;
                    end else if (i_mode == MODE_ATTACH) begin
                        w_pos = w_has ? r_cursor + 1'b1 : r_count;
                    end else if (i_mode == MODE_INSERT_FRONT) begin
                        w_pos = '0;
                    end else begin
                        w_pos = r_count;
                    end
                    w_op     = SHIFT_OPEN;
                    n_cursor = w_pos;
                    n_count  = r_count + 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (!w_has) begin
                    w_status = STATUS_NO_ITEM;
                end else begin
                    w_op    = SHIFT_CLOSE;
                    w_pos   = r_cursor;
                    n_count = r_count - 1'b1;
                end
            end
            MODE_REMOVE_FRONT: begin
                if (r_count == '0) begin
                    w_status = STATUS_NO_ITEM;
                end else begin
                    w_op    = SHIFT_CLOSE;
                    w_pos   = '0;
                    n_count = r_count - 1'b1;
                end
            end
            MODE_READ_INDEX: begin
                if (CNT_BITS'(i_read_idx) >= r_count) w_status = STATUS_BAD_INDEX;
            end
            default: begin
                w_status = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
        end else if (i_fire) begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
    end

    // Shift position always lies below the capacity when a shift is issued.
    assign o_shift.op   = i_fire ? w_op : SHIFT_HOLD;
    assign o_shift.pos  = w_pos[IDX_BITS-1:0];
    assign o_shift.word = i_word;
    assign o_status     = w_status;
    assign o_count      = r_count;
    assign o_cursor     = r_cursor;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(CAPACITY_ENTRIES))
        else $error("entry count above capacity");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_status == STATUS_FULL) |=> $stable(r_count) && $stable(r_cursor))
        else $error("rejected insert changed state");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_op == SHIFT_CLOSE) |=> (r_count == $past(r_count) - 1'b1))
        else $error("remove did not drop one entry");

    a_open_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_op == SHIFT_OPEN) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not add one entry");

endmodule

// File: verif/cursor_sequence_buffer_test.sv
// Testbench: random and directed requests against a cursor list predictor with response checks.
`timescale 1ns / 1ps
module cursor_sequence_buffer_test;
    import csb_pkg::*;

    // One request as the sender presents it.
    typedef struct packed {
        logic [MODE_BITS-1:0]     mode;
        logic [WORD_BITS-1:0]     entry_value;
        logic [READ_IDX_BITS-1:0] read_index;
    } t_list_request;

    // One response as the block returns it.
    typedef struct packed {
        logic [WORD_BITS-1:0]    item_value;
        logic                    has_item;
        logic [OUT_CNT_BITS-1:0] item_count;
        logic [OUT_CNT_BITS-1:0] cursor_pos;
        logic [STATUS_BITS-1:0]  status;
    } t_list_response;

    // Flavors of random bursts: grow the list, shrink it, or mix everything.
    typedef enum int {BURST_GROW, BURST_SHRINK, BURST_MIXED} t_burst_kind;

    localparam int RANDOM_REQUESTS = 1200;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_NS     = 2_000_000;

    logic i_clk;
    logic i_rst_n;

    csb_req_if req_if ();
    csb_rsp_if rsp_if ();

    cursor_sequence_buffer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the list: words, length and cursor, updated per accepted request.
    logic [WORD_BITS-1:0] shadow_words [CAPACITY_ENTRIES];
    int                   shadow_len;
    int                   shadow_cursor;

    t_list_request  pending_requests [$];  // requests not yet presented to the block
    t_list_response awaited_responses [$]; // predicted responses, oldest first

    int             total_requests;
    int             sent_requests;
    int             fail_count;
    int             send_idle_pct;
    int             recv_idle_pct;
    logic           req_fired;   // request taken at the last rising edge
    t_list_request  next_request;
    t_list_request  taken_request;
    t_list_response seen_response;
    t_list_response want_response;

    // Shift the tail up by one and drop the word into the gap.
    function automatic void open_gap(int pos, logic [WORD_BITS-1:0] word);
        for (int i = shadow_len; i > pos; i--) begin
            shadow_words[i] = shadow_words[i - 1];
        end
        shadow_words[pos] = word;
        shadow_len++;
    endfunction

    // Shift the tail down by one over the removed slot.
    function automatic void close_gap(int pos);
        for (int i = pos; i + 1 < shadow_len; i++) begin
            shadow_words[i] = shadow_words[i + 1];
        end
        shadow_len--;
    endfunction

    // Apply one request to the shadow list and return the response it must produce.
    function automatic t_list_response predict_response(t_list_request rq);
        t_list_response rsp;
        logic           has_cur;
        logic           is_full;
        logic [STATUS_BITS-1:0] st;

        has_cur = shadow_cursor < shadow_len;
        is_full = shadow_len >= CAPACITY_ENTRIES;
        st      = STATUS_OK;

        case (rq.mode)
            MODE_START:   shadow_cursor = 0;
            MODE_END:     shadow_cursor = (shadow_len > 0) ? shadow_len - 1 : 0;
            MODE_ADVANCE: begin
                if (!has_cur) st = STATUS_NO_ITEM;
                else shadow_cursor++;
            end
            MODE_RETREAT: begin
                if (shadow_cursor > 0) shadow_cursor--;
            end
            MODE_INSERT: begin
                if (is_full) begin
                    st = STATUS_FULL;
                end else begin
                    // With nothing under the cursor the word lands at the front.
                    if (!has_cur) shadow_cursor = 0;
                    open_gap(shadow_cursor, rq.entry_value);
                end
            end
            MODE_ATTACH: begin
                if (is_full) begin
                    st = STATUS_FULL;
                end else begin
                    // With nothing under the cursor the word lands at the back.
                    shadow_cursor = has_cur ? shadow_cursor + 1 : shadow_len;
                    open_gap(shadow_cursor, rq.entry_value);
                end
            end
            MODE_REMOVE: begin
                if (!has_cur) st = STATUS_NO_ITEM;
                else close_gap(shadow_cursor);
            end
            MODE_INSERT_FRONT: begin
                if (is_full) begin
                    st = STATUS_FULL;
                end else begin
                    shadow_cursor = 0;
                    open_gap(0, rq.entry_value);
                end
            end
            MODE_ATTACH_BACK: begin
                if (is_full) begin
                    st = STATUS_FULL;
                end else begin
                    shadow_cursor = shadow_len;
                    open_gap(shadow_len, rq.entry_value);
                end
            end
            MODE_REMOVE_FRONT: begin
                // The cursor keeps its position, even past the new length.
                if (shadow_len == 0) st = STATUS_NO_ITEM;
                else close_gap(0);
            end
            default: ;
        endcase

        has_cur = shadow_cursor < shadow_len;
        if (rq.mode == MODE_READ_INDEX) begin
            if (int'(rq.read_index) < shadow_len) begin
                rsp.item_value = shadow_words[rq.read_index];
            end else begin
                rsp.item_value = '0;
                st             = STATUS_BAD_INDEX;
            end
        end else begin
            rsp.item_value = has_cur ? shadow_words[shadow_cursor] : '0;
        end
        rsp.has_item   = has_cur;
        rsp.item_count = OUT_CNT_BITS'(shadow_len);
        rsp.cursor_pos = OUT_CNT_BITS'(shadow_cursor);
        rsp.status     = st;
        return rsp;
    endfunction

    function automatic void queue_request(logic [MODE_BITS-1:0] mode,
                                          logic [WORD_BITS-1:0] word,
                                          logic [READ_IDX_BITS-1:0] idx);
        t_list_request rq;
        rq.mode        = mode;
        rq.entry_value = word;
        rq.read_index  = idx;
        pending_requests.push_back(rq);
    endfunction

    // Mostly random words, with all-zero and all-one words mixed in.
    function automatic logic [WORD_BITS-1:0] random_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return '0;
        if (roll < 20) return '1;
        return $urandom;
    endfunction

    function automatic logic [MODE_BITS-1:0] random_mode(t_burst_kind kind);
        int roll;
        roll = $urandom_range(99);
        if (kind == BURST_GROW && roll < 70) begin
            case ($urandom_range(3))
                0:       return MODE_INSERT;
                1:       return MODE_ATTACH;
                2:       return MODE_INSERT_FRONT;
                default: return MODE_ATTACH_BACK;
            endcase
        end
        if (kind == BURST_SHRINK && roll < 65) begin
            return ($urandom_range(1) == 0) ? MODE_REMOVE : MODE_REMOVE_FRONT;
        end
        // Keep codes past the last operation rare; they only echo the state.
        if (roll < 4) return MODE_BITS'($urandom_range(MODE_READ_INDEX + 1, (1 << MODE_BITS) - 1));
        return MODE_BITS'($urandom_range(MODE_START, MODE_READ_INDEX));
    endfunction

    function automatic void check_field(string name, logic [WORD_BITS-1:0] want,
                                        logic [WORD_BITS-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
            fail_count++;
        end
    endfunction

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bail out if the run hangs.
    initial begin
        #(WATCHDOG_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Driver: present requests at the falling edge and pick the receiver's ready there too.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            rsp_if.ready <= 1'b0;
        end else begin
            // Split the run in thirds: receiver-heavy idling, sender-heavy idling, none.
            if (sent_requests * 3 < total_requests) begin
                send_idle_pct = 29;
                recv_idle_pct = 54;
            end else if (sent_requests * 3 < total_requests * 2) begin
                send_idle_pct = 54;
                recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // Hold a request that has not been taken yet; otherwise advance or idle.
            if (!req_if.valid || req_fired) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_request = pending_requests.pop_front();
                    req_if.mode        <= next_request.mode;
                    req_if.entry_value <= next_request.entry_value;
                    req_if.read_index  <= next_request.read_index;
                    req_if.valid       <= 1'b1;
                    sent_requests++;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: sample both channels at the rising edge, check responses, predict new ones.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_fired <= 1'b0;
        end else begin
            req_fired <= req_if.valid && req_if.ready;

            // Check first so a response never meets the request taken in the same edge.
            if (rsp_if.valid && rsp_if.ready) begin
                seen_response.item_value = rsp_if.item_value;
                seen_response.has_item   = rsp_if.has_item;
                seen_response.item_count = rsp_if.item_count;
                seen_response.cursor_pos = rsp_if.cursor_pos;
                seen_response.status     = rsp_if.status;
                if (awaited_responses.size() == 0) begin
                    $display("%0t: unexpected response, expected none, got %0h",
                             $realtime, seen_response);
                    fail_count++;
                end else begin
                    want_response = awaited_responses.pop_front();
                    check_field("item_value", want_response.item_value,
                                seen_response.item_value);
                    check_field("has_item", WORD_BITS'(want_response.has_item),
                                WORD_BITS'(seen_response.has_item));
                    check_field("item_count", WORD_BITS'(want_response.item_count),
                                WORD_BITS'(seen_response.item_count));
                    check_field("cursor_pos", WORD_BITS'(want_response.cursor_pos),
                                WORD_BITS'(seen_response.cursor_pos));
                    check_field("status", WORD_BITS'(want_response.status),
                                WORD_BITS'(seen_response.status));
                end
            end

            if (req_if.valid && req_if.ready) begin
                taken_request.mode        = req_if.mode;
                taken_request.entry_value = req_if.entry_value;
                taken_request.read_index  = req_if.read_index;
                awaited_responses.push_back(predict_response(taken_request));
            end
        end
    end

    // Main sequence: build the stimulus, reset once, drain, report.
    initial begin
        t_burst_kind kind;
        int          burst_len;
        int          roll;
        int          generated;

        // Drive every input to a known value before the first edge.
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.mode        = MODE_START;
        req_if.entry_value = '0;
        req_if.read_index  = '0;
        rsp_if.ready       = 1'b0;
        req_fired          = 1'b0;
        shadow_len         = 0;
        shadow_cursor      = 0;
        sent_requests      = 0;
        fail_count         = 0;
        send_idle_pct      = 0;
        recv_idle_pct      = 0;

        // Directed part: walk the empty list corner cases, then the edges of a small list.
        queue_request(MODE_REMOVE_FRONT, '0, '0);             // remove front on empty
        queue_request(MODE_END, '0, '0);                      // end on empty keeps zero
        queue_request(MODE_ADVANCE, '0, '0);                  // advance without an item
        queue_request(MODE_REMOVE, '0, '0);                   // remove without an item
        queue_request(MODE_RETREAT, '0, '0);                  // retreat at zero stays put
        queue_request(MODE_READ_INDEX, '0, '1);               // read past the count
        queue_request(MODE_INSERT, '0, '0);                   // insert with no item: front
        queue_request(MODE_ADVANCE, '0, '0);                  // step past the last entry
        queue_request(MODE_ADVANCE, '0, '0);                  // stop at the count
        queue_request(MODE_ATTACH, '1, '0);                   // attach with no item: back
        queue_request(MODE_INSERT_FRONT, 32'ha5a5_a5a5, '0);
        queue_request(MODE_ATTACH_BACK, 32'h5a5a_5a5a, '0);
        queue_request(MODE_START, '0, '0);
        queue_request(MODE_ATTACH, 32'h1234_5678, '0);
        queue_request(MODE_INSERT, 32'hdead_beef, '0);
        queue_request(MODE_END, '0, '0);
        queue_request(MODE_REMOVE, '0, '0);                   // remove the last entry
        queue_request(MODE_RETREAT, '0, '0);
        queue_request(MODE_READ_INDEX, '0, '0);
        queue_request(MODE_READ_INDEX, '1, READ_IDX_BITS'(4)); // last valid index
        queue_request(MODE_READ_INDEX, '0, READ_IDX_BITS'(5)); // first bad index
        queue_request(MODE_REMOVE_FRONT, '0, '0);
        queue_request(MODE_BITS'(MODE_READ_INDEX + 1), '1, '1); // unused code: no change
        queue_request('1, '0, '0);                            // highest unused code

        // Random part: bursts that fill to full, drain to empty, or wander around.
        generated = 0;
        while (generated < RANDOM_REQUESTS) begin
            roll = $urandom_range(99);
            if (roll < 35) kind = BURST_GROW;
            else if (roll < 60) kind = BURST_SHRINK;
            else kind = BURST_MIXED;
            burst_len = $urandom_range(8, 48);
            for (int n = 0; n < burst_len; n++) begin
                queue_request(random_mode(kind), random_word(),
                              READ_IDX_BITS'($urandom_range(CAPACITY_ENTRIES - 1)));
            end
            generated += burst_len;
        end
        total_requests = pending_requests.size();

        // Hold reset, then release it at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all requests taken and every predicted response seen.
        while (pending_requests.size() != 0 || req_if.valid
               || awaited_responses.size() != 0) begin
            @(posedge i_clk);
        end
        // Wait out the settle cycles to catch stray responses.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
